### rtl/pei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pei_pkg
// Shared types, codes and saturation helper for the particle integrator.
// ----------------------------------------------------------------------------
package pei_pkg;

	localparam logic [2:0] OP_SET_POS = 3'd0;
	localparam logic [2:0] OP_SET_VEL = 3'd1;
	localparam logic [2:0] OP_SET_MASS = 3'd2;
	localparam logic [2:0] OP_ADD_FORCE = 3'd3;
	localparam logic [2:0] OP_STEP = 3'd4;
	localparam logic [2:0] OP_READ = 3'd5;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_NOT_LIVE = 2'd1;
	localparam logic [1:0] STAT_ZERO_MASS = 2'd2;
	localparam logic [1:0] STAT_SAT = 2'd3;

	typedef struct packed {
		logic        flag;
		logic [31:0] val;
	} sat_t;

	typedef struct packed {
		logic        start;
		logic [47:0] num;
		logic [26:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [48:0] quo;
	} div_rsp_t;

	function automatic sat_t sat32(input logic [49:0] v);
		sat_t r;
		if (v[49:31] == {19{1'b0}} || v[49:31] == {19{1'b1}}) begin
			r.flag = 1'b0;
			r.val = v[31:0];
		end else begin
			r.flag = 1'b1;
			r.val = v[49] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		return r;
	endfunction

endpackage

### rtl/pei_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pei_div
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module pei_div
	import pei_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [47:0] num_q;
	logic [26:0] rem_q;
	logic [26:0] den_q;
	logic        neg_q;
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [27:0] trial;
	logic        fits;
	logic [48:0] mag;

	assign trial = {rem_q, num_q[47]};
	assign fits = trial >= {1'b0, den_q};
	assign mag = {1'b0, num_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd47;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num[47] ? (48'd0 - req.num) : req.num;
			neg_q <= req.num[47];
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 27'(trial - {1'b0, den_q}) : trial[26:0];
			num_q <= {num_q[46:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = neg_q ? (49'd0 - mag) : mag;

endmodule

### rtl/pei_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pei_mul
// Shared multiply by dt: registered product, then truncating shift, add, sat.
// ----------------------------------------------------------------------------
module pei_mul
	import pei_pkg::*;
(
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [15:0] dt,
	input  logic [31:0] base,
	output sat_t        res
);

	logic signed [48:0] p_s1;
	logic [48:0]        mag;
	logic [32:0]        sh;
	logic [33:0]        t;

	always_ff @(posedge clk) begin
		p_s1 <= $signed({{17{a[31]}}, a}) * $signed({33'd0, dt});
	end

	assign mag = p_s1[48] ? (49'd0 - p_s1) : p_s1;
	assign sh = mag[48:16];
	assign t = p_s1[48] ? (34'd0 - {1'b0, sh}) : {1'b0, sh};
	assign res = sat32({{18{base[31]}}, base} + {{16{t[33]}}, t});

endmodule

### rtl/particle_euler_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_euler_integrator
// Fixed-point particle store with semi-implicit Euler step and box culling.
// ----------------------------------------------------------------------------
// Set position/velocity/mass: write in S_EXEC, result in S_OUT; read: S_RD_W, S_RD_C, then S_OUT.
// Add force: two 48-step passes of the shared divider, x then y.
// Step: S_T_LD, S_T_M0..S_T_M3, S_T_WB per live particle via the shared multiplier,
// then load/test per box check, load/copy per moved particle; one item in flight at a time.
// After reset a clearing pass over all MAX_PARTICLES entries zeroes acceleration;
// no item is taken meanwhile, register writes are.
module particle_euler_integrator
	import pei_pkg::*;
#(
	parameter int MAX_PARTICLES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic [11:0]        index,
	input  logic signed [47:0] value_x,
	input  logic signed [47:0] value_y,
	input  logic [26:0]        mass_value,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_vel_x,
	output logic signed [31:0] out_vel_y,
	output logic [26:0]        out_mass,
	output logic [12:0]        live_total,
	output logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES + 1);

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	localparam logic [4:0] S_CLR = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_EXEC = 5'd2;
	localparam logic [4:0] S_RD_W = 5'd3;
	localparam logic [4:0] S_RD_C = 5'd4;
	localparam logic [4:0] S_F_W = 5'd5;
	localparam logic [4:0] S_F_C = 5'd6;
	localparam logic [4:0] S_F_X = 5'd7;
	localparam logic [4:0] S_F_Y = 5'd8;
	localparam logic [4:0] S_T_LD = 5'd9;
	localparam logic [4:0] S_T_M0 = 5'd10;
	localparam logic [4:0] S_T_M1 = 5'd11;
	localparam logic [4:0] S_T_M2 = 5'd12;
	localparam logic [4:0] S_T_M3 = 5'd13;
	localparam logic [4:0] S_T_WB = 5'd14;
	localparam logic [4:0] S_C_LD = 5'd15;
	localparam logic [4:0] S_C_T = 5'd16;
	localparam logic [4:0] S_CP_LD = 5'd17;
	localparam logic [4:0] S_CP_WR = 5'd18;
	localparam logic [4:0] S_OUT = 5'd19;

	logic [4:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] live_q;
	logic [AW-1:0] ra_q;
	logic [2:0]    op_q;
	logic [47:0]   vx_q;
	logic [47:0]   vy_q;
	logic [26:0]   mv_q;
	logic [15:0]   dt_q;
	logic          sat_q;
	logic [1:0]    stat_q;
	logic [31:0]   res_px_q, res_py_q, res_vx_q, res_vy_q;
	logic [26:0]   res_m_q;
	logic [31:0]   vxn_q, vyn_q, pxn_q;
	logic [15:0]   ww_q, wh_q;
	logic [12:0]   pc_q;
	logic          out_valid_q;
	logic [31:0]   o_px_q, o_py_q, o_vx_q, o_vy_q;
	logic [26:0]   o_m_q;
	logic [12:0]   o_live_q;
	logic [1:0]    o_stat_q;

	logic [31:0] pos_x_mem [MAX_PARTICLES];
	logic [31:0] pos_y_mem [MAX_PARTICLES];
	logic [31:0] vel_x_mem [MAX_PARTICLES];
	logic [31:0] vel_y_mem [MAX_PARTICLES];
	logic [31:0] acc_x_mem [MAX_PARTICLES];
	logic [31:0] acc_y_mem [MAX_PARTICLES];
	logic [26:0] mass_mem [MAX_PARTICLES];
	logic [31:0] pos_x_rd_q, pos_y_rd_q, vel_x_rd_q, vel_y_rd_q, acc_x_rd_q, acc_y_rd_q;
	logic [26:0] mass_rd_q;

	logic          we_pos, we_vel, we_mass, we_ax, we_ay;
	logic [AW-1:0] wa;
	logic [31:0]   wd_px, wd_py, wd_vx, wd_vy, wd_ax, wd_ay;
	logic [26:0]   wd_m;

	div_req_t    dreq;
	div_rsp_t    drsp;
	logic [31:0] mul_a, mul_base;
	sat_t        mres;
	sat_t        sx, sy, fsum;
	logic [31:0] acc_sel;

	logic          accept;
	logic          idx_live;
	logic          cfg_wr;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] cnt_dec;
	logic [CW-1:0] live_dec;
	logic [AW-1:0] idx_a;
	logic          outside;
	logic [27:0]   xmax, ymax;
	logic          out_free;

	assign accept = in_valid && in_ready;
	assign in_ready = state_q == S_IDLE;
	assign idx_live = 32'(index) < 32'(live_q);
	assign idx_a = AW'(index);
	assign cfg_wr = psel && penable && pwrite;
	assign cnt_inc = cnt_q + CW'(1);
	assign cnt_dec = cnt_q - CW'(1);
	assign live_dec = live_q - CW'(1);
	assign out_free = !out_valid_q || out_ready;
	assign pready = 1'b1;

	assign xmax = {ww_q, 12'd0};
	assign ymax = {wh_q, 12'd0};
	assign outside = pos_x_rd_q[31] || pos_y_rd_q[31]
		|| (pos_x_rd_q[30:0] > {3'd0, xmax}) || (pos_y_rd_q[30:0] > {3'd0, ymax});

	assign sx = sat32({{2{vx_q[47]}}, vx_q});
	assign sy = sat32({{2{vy_q[47]}}, vy_q});

	pei_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);

	assign dreq.start = (state_q == S_F_C && mass_rd_q != 27'd0)
		|| (state_q == S_F_X && drsp.done);
	assign dreq.num = (state_q == S_F_C) ? vx_q : vy_q;
	assign dreq.den = mass_rd_q;

	assign acc_sel = (state_q == S_F_X) ? acc_x_rd_q : acc_y_rd_q;
	assign fsum = sat32({{18{acc_sel[31]}}, acc_sel} + {drsp.quo[48], drsp.quo});

	pei_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.dt  (dt_q),
		.base(mul_base),
		.res (mres)
	);

	always_comb begin
		mul_a = acc_x_rd_q;
		mul_base = pos_y_rd_q;
		case (state_q)
			S_T_M1: begin
				mul_a = acc_y_rd_q;
				mul_base = vel_x_rd_q;
			end
			S_T_M2: begin
				mul_a = vxn_q;
				mul_base = vel_y_rd_q;
			end
			S_T_M3: begin
				mul_a = vyn_q;
				mul_base = pos_x_rd_q;
			end
			default: begin
				mul_a = acc_x_rd_q;
				mul_base = pos_y_rd_q;
			end
		endcase
	end

	// store write port
	always_comb begin
		we_pos = 1'b0;
		we_vel = 1'b0;
		we_mass = 1'b0;
		we_ax = 1'b0;
		we_ay = 1'b0;
		wa = ra_q;
		wd_px = sx.val;
		wd_py = sy.val;
		wd_vx = sx.val;
		wd_vy = sy.val;
		wd_m = mv_q;
		wd_ax = '0;
		wd_ay = '0;
		case (state_q)
			S_CLR: begin
				wa = cnt_q[AW-1:0];
				we_ax = 1'b1;
				we_ay = 1'b1;
			end
			S_EXEC: begin
				we_pos = op_q == OP_SET_POS;
				we_vel = op_q == OP_SET_VEL;
				we_mass = op_q == OP_SET_MASS;
			end
			S_F_X: begin
				we_ax = drsp.done;
				wd_ax = fsum.val;
			end
			S_F_Y: begin
				we_ay = drsp.done;
				wd_ay = fsum.val;
			end
			S_T_WB: begin
				we_pos = 1'b1;
				we_vel = 1'b1;
				we_ax = 1'b1;
				we_ay = 1'b1;
				wd_px = pxn_q;
				wd_py = mres.val;
				wd_vx = vxn_q;
				wd_vy = vyn_q;
			end
			S_CP_WR: begin
				wa = cnt_q[AW-1:0];
				we_pos = 1'b1;
				we_vel = 1'b1;
				we_mass = 1'b1;
				wd_px = pos_x_rd_q;
				wd_py = pos_y_rd_q;
				wd_vx = vel_x_rd_q;
				wd_vy = vel_y_rd_q;
				wd_m = mass_rd_q;
			end
			default: begin
				wa = ra_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_pos) begin
			pos_x_mem[wa] <= wd_px;
			pos_y_mem[wa] <= wd_py;
		end
		pos_x_rd_q <= pos_x_mem[ra_q];
		pos_y_rd_q <= pos_y_mem[ra_q];
	end

	always_ff @(posedge clk) begin
		if (we_vel) begin
			vel_x_mem[wa] <= wd_vx;
			vel_y_mem[wa] <= wd_vy;
		end
		vel_x_rd_q <= vel_x_mem[ra_q];
		vel_y_rd_q <= vel_y_mem[ra_q];
	end

	always_ff @(posedge clk) begin
		if (we_ax) begin
			acc_x_mem[wa] <= wd_ax;
		end
		acc_x_rd_q <= acc_x_mem[ra_q];
	end

	always_ff @(posedge clk) begin
		if (we_ay) begin
			acc_y_mem[wa] <= wd_ay;
		end
		acc_y_rd_q <= acc_y_mem[ra_q];
	end

	always_ff @(posedge clk) begin
		if (we_mass) begin
			mass_mem[wa] <= wd_m;
		end
		mass_rd_q <= mass_mem[ra_q];
	end

	// configuration
	always_comb begin
		case (paddr[3:2])
			REG_WIDTH: prdata = {16'd0, ww_q};
			REG_HEIGHT: prdata = {16'd0, wh_q};
			REG_COUNT: prdata = {19'd0, pc_q};
			default: prdata = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q <= '0;
			live_q <= '0;
			ww_q <= 16'd4096;
			wh_q <= 16'd4096;
			pc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_WIDTH: ww_q <= pwdata[15:0];
					REG_HEIGHT: wh_q <= pwdata[15:0];
					REG_COUNT: begin
						pc_q <= pwdata[12:0];
						live_q <= (32'(pwdata[12:0]) > 32'(MAX_PARTICLES))
							? CW'(MAX_PARTICLES) : CW'(pwdata[12:0]);
					end
					default: ;
				endcase
			end
			case (state_q)
				S_CLR: begin
					cnt_q <= cnt_inc;
					if (32'(cnt_q) == 32'(MAX_PARTICLES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_STEP) begin
							cnt_q <= '0;
							state_q <= (live_q == '0) ? S_OUT : S_T_LD;
						end else if (opcode > OP_READ) begin
							state_q <= S_OUT;
						end else if (!idx_live) begin
							state_q <= S_OUT;
						end else if (opcode == OP_ADD_FORCE) begin
							state_q <= S_F_W;
						end else if (opcode == OP_READ) begin
							state_q <= S_RD_W;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: state_q <= S_OUT;
				S_RD_W: state_q <= S_RD_C;
				S_RD_C: state_q <= S_OUT;
				S_F_W: state_q <= S_F_C;
				S_F_C: state_q <= (mass_rd_q == 27'd0) ? S_OUT : S_F_X;
				S_F_X: begin
					if (drsp.done) begin
						state_q <= S_F_Y;
					end
				end
				S_F_Y: begin
					if (drsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_T_LD: state_q <= S_T_M0;
				S_T_M0: state_q <= S_T_M1;
				S_T_M1: state_q <= S_T_M2;
				S_T_M2: state_q <= S_T_M3;
				S_T_M3: state_q <= S_T_WB;
				S_T_WB: begin
					if (cnt_inc == live_q) begin
						cnt_q <= live_dec;
						state_q <= S_C_LD;
					end else begin
						cnt_q <= cnt_inc;
						state_q <= S_T_LD;
					end
				end
				S_C_LD: state_q <= S_C_T;
				S_C_T: begin
					if (outside && cnt_q != live_dec) begin
						state_q <= S_CP_LD;
					end else begin
						if (outside) begin
							live_q <= live_dec;
						end
						if (cnt_q == '0) begin
							state_q <= S_OUT;
						end else begin
							cnt_q <= cnt_dec;
							state_q <= S_C_LD;
						end
					end
				end
				S_CP_LD: state_q <= S_CP_WR;
				S_CP_WR: begin
					live_q <= live_dec;
					if (cnt_q == '0) begin
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_dec;
						state_q <= S_C_LD;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q <= opcode;
					vx_q <= value_x;
					vy_q <= value_y;
					mv_q <= mass_value;
					dt_q <= time_step;
					ra_q <= (opcode == OP_STEP) ? '0 : idx_a;
					sat_q <= 1'b0;
					res_px_q <= '0;
					res_py_q <= '0;
					res_vx_q <= '0;
					res_vy_q <= '0;
					res_m_q <= '0;
					stat_q <= (opcode <= OP_READ && opcode != OP_STEP && !idx_live)
						? STAT_NOT_LIVE : STAT_OK;
				end
			end
			S_EXEC: begin
				if (op_q != OP_SET_MASS) begin
					sat_q <= sx.flag || sy.flag;
				end
			end
			S_RD_C: begin
				res_px_q <= pos_x_rd_q;
				res_py_q <= pos_y_rd_q;
				res_vx_q <= vel_x_rd_q;
				res_vy_q <= vel_y_rd_q;
				res_m_q <= mass_rd_q;
			end
			S_F_C: begin
				if (mass_rd_q == 27'd0) begin
					stat_q <= STAT_ZERO_MASS;
				end
			end
			S_F_X, S_F_Y: begin
				if (drsp.done) begin
					sat_q <= sat_q || fsum.flag;
				end
			end
			S_T_M1: begin
				vxn_q <= mres.val;
				sat_q <= sat_q || mres.flag;
			end
			S_T_M2: begin
				vyn_q <= mres.val;
				sat_q <= sat_q || mres.flag;
			end
			S_T_M3: begin
				pxn_q <= mres.val;
				sat_q <= sat_q || mres.flag;
			end
			S_T_WB: begin
				sat_q <= sat_q || mres.flag;
				ra_q <= (cnt_inc == live_q) ? live_dec[AW-1:0] : cnt_inc[AW-1:0];
			end
			S_C_T: begin
				if (outside && cnt_q != live_dec) begin
					ra_q <= live_dec[AW-1:0];
				end else if (cnt_q != '0) begin
					ra_q <= cnt_dec[AW-1:0];
				end
			end
			S_CP_WR: begin
				if (cnt_q != '0) begin
					ra_q <= cnt_dec[AW-1:0];
				end
			end
			S_OUT: begin
				if (out_free) begin
					o_px_q <= res_px_q;
					o_py_q <= res_py_q;
					o_vx_q <= res_vx_q;
					o_vy_q <= res_vy_q;
					o_m_q <= res_m_q;
					o_live_q <= 13'(live_q);
					o_stat_q <= (sat_q && stat_q == STAT_OK) ? STAT_SAT : stat_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_pos_x = o_px_q;
	assign out_pos_y = o_py_q;
	assign out_vel_x = o_vx_q;
	assign out_vel_y = o_vy_q;
	assign out_mass = o_m_q;
	assign live_total = o_live_q;
	assign status = o_stat_q;

endmodule

### rtl/pei_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pei_checker
// Port-level checks on the particle integrator, bound to the top level.
// ----------------------------------------------------------------------------
module pei_checker
	import pei_pkg::*;
#(
	parameter int MAX_PARTICLES = 4096
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_pos_x,
	input logic [31:0] out_vel_y,
	input logic [26:0] out_mass,
	input logic [12:0] live_total,
	input logic [1:0]  status
);

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in flight");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(live_total) <= 32'(MAX_PARTICLES))
		else $error("live count above capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_NOT_LIVE || status == STAT_ZERO_MASS)
		|-> out_pos_x == '0 && out_vel_y == '0 && out_mass == '0)
		else $error("failed item carries particle data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(live_total))
		else $error("stalled result changed");

endmodule

bind particle_euler_integrator pei_checker #(.MAX_PARTICLES(MAX_PARTICLES)) u_pei_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_pos_x (out_pos_x),
	.out_vel_y (out_vel_y),
	.out_mass  (out_mass),
	.live_total(live_total),
	.status    (status)
);
